### hw/rtl/ucd_pkg.sv
// Package for the UTF-8 code point decoder.
// Holds the byte class codes and the classified item type.
// No dependencies.
`timescale 1ns / 1ps

package ucd_pkg;

    // Width of a decoded code point.
    localparam int unsigned CP_W = 21;
    // Widest payload a single byte can carry (an ASCII byte has seven bits).
    localparam int unsigned PAYLOAD_W = 7;

    // Byte classes found by the front end.
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_ASCII   = 3'd0;
    localparam t_kind KIND_CONT    = 3'd1;
    localparam t_kind KIND_LEAD2   = 3'd2;
    localparam t_kind KIND_LEAD3   = 3'd3;
    localparam t_kind KIND_LEAD4   = 3'd4;
    localparam t_kind KIND_INVALID = 3'd5;

    // One classified byte, as it travels from the front end to the back end.
    typedef struct packed {
        t_kind                  kind;
        logic [PAYLOAD_W-1:0]   payload;
        logic                   last;
    } t_ucd_item;

endpackage

### hw/rtl/ucd_queue.sv
// Small first-in first-out queue with full and empty flags.
// Generic storage; depends on nothing.
`timescale 1ns / 1ps

module ucd_queue #(
    parameter int unsigned WIDTH      = 8,
    parameter int unsigned DEPTH_LOG2 = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int unsigned DEPTH = 1 << DEPTH_LOG2;

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wr_ptr;
    logic [DEPTH_LOG2-1:0] r_rd_ptr;
    logic [DEPTH_LOG2:0]   r_count;

    logic do_push;
    logic do_pop;

    // A transfer happens on each side only when the flags allow it.
    assign o_full  = (r_count == DEPTH_LOG2'(0) + (DEPTH_LOG2 + 1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Storage array; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/ucd_front.sv
// Front end of the UTF-8 decoder: sorts each incoming byte into a class.
// Depends on ucd_pkg.
`timescale 1ns / 1ps

module ucd_front (
    input  logic              i_byte_in,
    input  logic [7:0]        i_byte,
    input  logic              i_end_of_string,
    output ucd_pkg::t_ucd_item o_item
);

    // Decode the high bits of the byte and keep its payload bits.
    always_comb begin
        o_item.last    = i_end_of_string && i_byte_in;
        o_item.kind    = ucd_pkg::KIND_INVALID;
        o_item.payload = '0;
        if (!i_byte[7]) begin
            o_item.kind    = ucd_pkg::KIND_ASCII;
            o_item.payload = i_byte[6:0];
        end else if (i_byte[7:6] == 2'b10) begin
            o_item.kind    = ucd_pkg::KIND_CONT;
            o_item.payload = {1'b0, i_byte[5:0]};
        end else if (i_byte[7:5] == 3'b110) begin
            o_item.kind    = ucd_pkg::KIND_LEAD2;
            o_item.payload = {2'b00, i_byte[4:0]};
        end else if (i_byte[7:4] == 4'b1110) begin
            o_item.kind    = ucd_pkg::KIND_LEAD3;
            o_item.payload = {3'b000, i_byte[3:0]};
        end else if (i_byte[7:3] == 5'b11110) begin
            o_item.kind    = ucd_pkg::KIND_LEAD4;
            o_item.payload = {4'b0000, i_byte[2:0]};
        end
    end

endmodule

### hw/rtl/ucd_back.sv
// Back end of the UTF-8 decoder: sequence state and code point assembly.
// Depends on ucd_pkg.
`timescale 1ns / 1ps

module ucd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_item_empty,
    input  ucd_pkg::t_ucd_item           i_item,
    output logic                         o_item_pop,
    input  logic                         i_out_full,
    output logic                         o_out_push,
    output logic [ucd_pkg::CP_W-1:0]     o_code_point
);

    logic [1:0]               r_pending;
    logic [1:0]               n_pending;
    logic [ucd_pkg::CP_W-1:0] r_acc;
    logic [ucd_pkg::CP_W-1:0] n_acc;
    logic [ucd_pkg::CP_W-1:0] emit_val;
    logic                     emit;
    logic                     advance;
    logic [1:0]               pend_dec;
    logic [ucd_pkg::CP_W-1:0] acc_shift;

    // One item is taken whenever one waits and the result queue has room.
    assign advance    = !i_item_empty && !i_out_full;
    assign o_item_pop = advance;
    assign o_out_push = advance && emit;
    assign o_code_point = emit_val;

    assign pend_dec  = r_pending - 2'd1;
    assign acc_shift = {r_acc[ucd_pkg::CP_W-7:0], i_item.payload[5:0]};

    // Next sequence state and the value that this item may emit.
    always_comb begin
        n_pending = '0;
        n_acc     = '0;
        emit_val  = '0;
        if ((r_pending != 2'd0) && (i_item.kind == ucd_pkg::KIND_CONT)) begin
            // Continuation inside a sequence shifts in six bits.
            if ((pend_dec == 2'd0) || i_item.last) begin
                emit_val = acc_shift;
            end else begin
                n_pending = pend_dec;
                n_acc     = acc_shift;
            end
        end else begin
            // Outside a sequence, or a broken one: decode as a lead byte.
            case (i_item.kind)
                ucd_pkg::KIND_ASCII: begin
                    emit_val = ucd_pkg::CP_W'(i_item.payload);
                end
                ucd_pkg::KIND_LEAD2: begin
                    n_pending = 2'd1;
                    n_acc     = ucd_pkg::CP_W'(i_item.payload);
                end
                ucd_pkg::KIND_LEAD3: begin
                    n_pending = 2'd2;
                    n_acc     = ucd_pkg::CP_W'(i_item.payload);
                end
                ucd_pkg::KIND_LEAD4: begin
                    n_pending = 2'd3;
                    n_acc     = ucd_pkg::CP_W'(i_item.payload);
                end
                default: begin
                    n_pending = '0;
                    n_acc     = '0;
                end
            endcase
            // A string that ends on a lead byte emits its partial value.
            if (i_item.last && (n_pending != 2'd0)) begin
                emit_val  = n_acc;
                n_pending = '0;
                n_acc     = '0;
            end
        end
    end

    // A zero value is never emitted.
    assign emit = (emit_val != '0);

    // Sequence state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_acc     <= '0;
        end else if (advance) begin
            r_pending <= n_pending;
            r_acc     <= n_acc;
        end
    end

endmodule

### hw/rtl/utf8_codepoint_decoder.sv
// Top level of the UTF-8 code point decoder.
// Depends on ucd_pkg, ucd_front, ucd_queue and ucd_back.
`timescale 1ns / 1ps

// Takes one byte of a UTF-8 string per transfer, with a flag on the string's
// last byte, and delivers decoded code points through a result queue. The
// block takes one byte every clock cycle while the input queue has room; the
// sequence state in the back end is updated once per byte, which sets that
// rate, and the back end stalls while the result queue is full. The byte that
// completes a result is registered in the input queue, the result in the result queue.
// Invalid lead bytes are skipped, a broken sequence is dropped and its byte is
// decoded again as a lead byte, a truncated sequence at string end yields its
// partial value, and a zero value never appears. Both internal queues hold
// 2**QUEUE_DEPTH_LOG2 entries, so either side may stall without stopping the
// other until a queue fills.
module utf8_codepoint_decoder #(
    parameter int unsigned QUEUE_DEPTH_LOG2 = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [7:0]               i_byte_in,
    input  logic                     i_end_of_string,
    output logic                     empty,
    input  logic                     pop,
    output logic [ucd_pkg::CP_W-1:0] o_code_point
);

    localparam int unsigned ITEM_W = $bits(ucd_pkg::t_ucd_item);

    ucd_pkg::t_ucd_item front_item;
    ucd_pkg::t_ucd_item back_item;
    logic [ITEM_W-1:0]  back_item_bits;
    logic               mid_empty;
    logic               mid_pop;
    logic               out_full;
    logic               out_push;
    logic [ucd_pkg::CP_W-1:0] back_cp;

    // Classify the incoming byte.
    ucd_front u_front (
        .i_byte_in       (1'b1),
        .i_byte          (i_byte_in),
        .i_end_of_string (i_end_of_string),
        .o_item          (front_item)
    );

    // Queue between front and back end.
    ucd_queue #(
        .WIDTH      (ITEM_W),
        .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .i_pop   (mid_pop),
        .o_full  (full),
        .o_empty (mid_empty),
        .o_data  (back_item_bits)
    );

    assign back_item = ucd_pkg::t_ucd_item'(back_item_bits);

    // Sequence state and code point assembly.
    ucd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_empty (mid_empty),
        .i_item       (back_item),
        .o_item_pop   (mid_pop),
        .i_out_full   (out_full),
        .o_out_push   (out_push),
        .o_code_point (back_cp)
    );

    // Result queue toward the consumer.
    ucd_queue #(
        .WIDTH      (ucd_pkg::CP_W),
        .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_cp),
        .i_pop   (pop),
        .o_full  (out_full),
        .o_empty (empty),
        .o_data  (o_code_point)
    );

endmodule

### tb/utf8_decoder_checker.sv
// Checker for the UTF-8 code point decoder: predicts code points from the byte transfers
// and compares them with the result transfers, in order.
// Depends on ucd_pkg for the code point width and the byte class codes.
`timescale 1ns / 1ps

module utf8_decoder_checker (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic                     i_full,
    input  logic [7:0]               i_byte_in,
    input  logic                     i_end_of_string,
    input  logic                     i_empty,
    input  logic                     i_pop,
    input  logic [ucd_pkg::CP_W-1:0] i_code_point,
    output int unsigned              o_mismatches,
    output int unsigned              o_outstanding
);

    localparam int unsigned REPORT_LIMIT = 10;

    // Predicted sequence state: continuation bytes still due and the partial value.
    logic [1:0]               seq_remaining;
    logic [ucd_pkg::CP_W-1:0] partial_cp;

    // Code points predicted but not yet seen on the result side, oldest first.
    logic [ucd_pkg::CP_W-1:0] expected_code_points [$];
    int unsigned              mismatch_count;

    // Sorts a byte by its leading bits.
    function automatic ucd_pkg::t_kind byte_kind(input logic [7:0] b);
        if (b[7] == 1'b0) return ucd_pkg::KIND_ASCII;
        if (b[6] == 1'b0) return ucd_pkg::KIND_CONT;
        if (b[5] == 1'b0) return ucd_pkg::KIND_LEAD2;
        if (b[4] == 1'b0) return ucd_pkg::KIND_LEAD3;
        if (b[3] == 1'b0) return ucd_pkg::KIND_LEAD4;
        return ucd_pkg::KIND_INVALID;
    endfunction

    // Advances the predicted state by one byte and says whether a code point comes out.
    task automatic decode_byte(input logic [7:0] b, input logic last,
                               output logic hit, output logic [ucd_pkg::CP_W-1:0] cp);
        ucd_pkg::t_kind kind;
        kind = byte_kind(b);
        hit  = 1'b0;
        cp   = '0;
        if (seq_remaining != 2'd0) begin
            if (kind == ucd_pkg::KIND_CONT) begin
                partial_cp    = {partial_cp[ucd_pkg::CP_W-7:0], b[5:0]};
                seq_remaining = seq_remaining - 2'd1;
                if (seq_remaining == 2'd0 || last) begin
                    hit           = (partial_cp != '0);
                    cp            = partial_cp;
                    seq_remaining = 2'd0;
                    partial_cp    = '0;
                end
                return;
            end
            // A broken sequence loses its partial value; the byte starts over as a lead.
            seq_remaining = 2'd0;
            partial_cp    = '0;
        end
        case (kind)
            ucd_pkg::KIND_ASCII: begin
                hit = (b != 8'd0);
                cp  = ucd_pkg::CP_W'(b[6:0]);
                return;
            end
            ucd_pkg::KIND_LEAD2: begin
                partial_cp    = ucd_pkg::CP_W'(b[4:0]);
                seq_remaining = 2'd1;
            end
            ucd_pkg::KIND_LEAD3: begin
                partial_cp    = ucd_pkg::CP_W'(b[3:0]);
                seq_remaining = 2'd2;
            end
            ucd_pkg::KIND_LEAD4: begin
                partial_cp    = ucd_pkg::CP_W'(b[2:0]);
                seq_remaining = 2'd3;
            end
            default: begin
                // Stray continuation bytes and invalid leads are skipped.
                return;
            end
        endcase
        // A lead byte that ends the string gives up its payload as it stands.
        if (last) begin
            hit           = (partial_cp != '0);
            cp            = partial_cp;
            seq_remaining = 2'd0;
            partial_cp    = '0;
        end
    endtask

    task automatic note_mismatch(input string what, input logic [ucd_pkg::CP_W-1:0] want,
                                 input logic [ucd_pkg::CP_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: %s: expected code_point 0x%06h, actual 0x%06h",
                     $realtime, what, want, got);
        end
    endtask

    // Samples both channels at each rising edge; results are checked before new bytes
    // are predicted, since no byte can produce its code point in its own cycle.
    always @(posedge i_clk) begin
        logic                     hit;
        logic [ucd_pkg::CP_W-1:0] cp;
        logic [ucd_pkg::CP_W-1:0] want;
        if (!i_rst_n) begin
            seq_remaining = 2'd0;
            partial_cp    = '0;
            expected_code_points.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_code_points.size() == 0) begin
                    note_mismatch("unexpected result transfer", '0, i_code_point);
                end else begin
                    want = expected_code_points.pop_front();
                    if (i_code_point !== want) begin
                        note_mismatch("code_point mismatch", want, i_code_point);
                    end
                end
            end
            if (i_push && !i_full) begin
                decode_byte(i_byte_in, i_end_of_string, hit, cp);
                if (hit) expected_code_points = {expected_code_points, cp};
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= expected_code_points.size();
    end

endmodule

### tb/testbench.sv
// Top of the UTF-8 code point decoder testbench: clock, reset, byte stimulus, result
// side stalls, watchdog and verdict. Depends on ucd_pkg, utf8_codepoint_decoder and
// utf8_decoder_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned RESET_CYCLES  = 11;
    localparam int unsigned IDLE_PCT      = 15;
    localparam int unsigned RANDOM_BYTES  = 1200;
    localparam int unsigned STEADY_FIRST  = 500;
    localparam int unsigned STEADY_LAST   = 800;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned STALL_LIMIT   = 2000;

    // Directed bytes as {end_of_string, byte}: zero and top ASCII, one sequence of each
    // length up to the largest value, a stray continuation, invalid leads, a broken
    // sequence, a sequence cut short by string end, an overlong zero and a lone lead.
    localparam logic [8:0] DIRECTED_BYTES [25] = '{
        9'h000, 9'h07F,
        9'h0C3, 9'h0A9,
        9'h0E2, 9'h082, 9'h0AC,
        9'h0F0, 9'h09F, 9'h098, 9'h080,
        9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
        9'h080, 9'h0FF,
        9'h0E2, 9'h041,
        9'h0E2, 9'h182,
        9'h0C0, 9'h080,
        9'h1C5, 9'h1F8
    };

    logic                     i_clk           = 1'b0;
    logic                     i_rst_n         = 1'b0;
    logic                     push            = 1'b0;
    logic                     pop             = 1'b0;
    logic [7:0]               i_byte_in       = 8'd0;
    logic                     i_end_of_string = 1'b0;
    logic                     full;
    logic                     empty;
    logic [ucd_pkg::CP_W-1:0] o_code_point;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned random_bytes_sent = 0;
    int unsigned stall_cycles      = 0;
    logic        steady            = 1'b0;
    logic [7:0]  string_bytes [$];

    always #2 i_clk = ~i_clk;

    utf8_codepoint_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_byte_in       (i_byte_in),
        .i_end_of_string (i_end_of_string),
        .empty           (empty),
        .pop             (pop),
        .o_code_point    (o_code_point)
    );

    utf8_decoder_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_byte_in       (i_byte_in),
        .i_end_of_string (i_end_of_string),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_code_point    (o_code_point),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    // Result side: stalls at random, except during the steady stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            pop <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offers one byte, after an optional random gap, and waits for its transfer.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push            <= 1'b1;
        i_byte_in       <= b;
        i_end_of_string <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // Holds the sender back until every predicted code point has been delivered.
    task automatic wait_for_drain();
        push <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // Adds one byte at the end of the current string.
    task automatic append_byte(input logic [7:0] b);
        string_bytes = {string_bytes, b};
    endtask

    // Appends one character to the current string: mostly well-formed sequences with
    // random payload, the rest stray bytes, invalid leads, noise and possibly cut-short sequences.
    task automatic add_character();
        int unsigned pick;
        int unsigned conts;
        logic [31:0] v;
        pick = $urandom_range(99);
        v    = $urandom;
        if (pick < 28) begin
            append_byte({1'b0, v[6:0]});
        end else if (pick < 48) begin
            append_byte({3'b110, v[10:6]});
            append_byte({2'b10, v[5:0]});
        end else if (pick < 66) begin
            append_byte({4'b1110, v[15:12]});
            append_byte({2'b10, v[11:6]});
            append_byte({2'b10, v[5:0]});
        end else if (pick < 84) begin
            append_byte({5'b11110, v[20:18]});
            append_byte({2'b10, v[17:12]});
            append_byte({2'b10, v[11:6]});
            append_byte({2'b10, v[5:0]});
        end else if (pick < 88) begin
            append_byte({2'b10, v[5:0]});
        end else if (pick < 91) begin
            append_byte({5'b11111, v[2:0]});
        end else if (pick < 95) begin
            append_byte(v[31:24]);
        end else begin
            // Lead byte followed by from none up to as many continuation bytes as it needs.
            conts = $urandom_range(2, 4);
            append_byte(8'hFF << (8 - conts) | (v[7:0] >> (conts + 1)));
            for (int unsigned k = 1 + $urandom_range(conts - 1); k < conts; k++) begin
                append_byte({2'b10, v[13:8]});
            end
        end
    endtask

    initial begin
        int unsigned chars;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int unsigned k = 0; k < $size(DIRECTED_BYTES); k++) begin
            send_byte(DIRECTED_BYTES[k][7:0], DIRECTED_BYTES[k][8]);
        end
        wait_for_drain();

        // Random strings of one to six characters, the last byte flagged as string end.
        while (random_bytes_sent < RANDOM_BYTES) begin
            string_bytes.delete();
            chars = $urandom_range(1, 6);
            repeat (chars) add_character();
            foreach (string_bytes[k]) begin
                steady = (random_bytes_sent >= STEADY_FIRST)
                      && (random_bytes_sent < STEADY_LAST);
                send_byte(string_bytes[k], k == string_bytes.size() - 1);
                random_bytes_sent++;
            end
            if ($urandom_range(24) == 0) wait_for_drain();
        end
        steady = 1'b0;

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### utf8_codepoint_decoder.f
hw/rtl/ucd_pkg.sv
hw/rtl/ucd_queue.sv
hw/rtl/ucd_front.sv
hw/rtl/ucd_back.sv
hw/rtl/utf8_codepoint_decoder.sv
tb/utf8_decoder_checker.sv
tb/testbench.sv
